// ===== hdl/scw_pkg.sv =====
// ----------------------------------------------------------------------------
// scw_pkg
// Shared types and constants of the speckle contrast window block.
// ----------------------------------------------------------------------------
package scw_pkg;

    localparam int PIX_W      = 8;
    localparam int SQ_W       = 2 * PIX_W;
    localparam int REG_W      = 11;
    localparam int ROW_W      = 11;
    localparam int OUT_W      = 21;
    localparam int OUT_TDATA_W = 24;
    localparam int FRAC_BITS  = 16;
    localparam int SIZE_FLOOR = 5;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int CFG_IDX_W  = 2;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Item kinds on the input tuser
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_PAD   = 1'b1;

    // One window element: grey value and its square
    typedef struct packed {
        logic [SQ_W-1:0]  sq;
        logic [PIX_W-1:0] pix;
    } px_t;

endpackage

// ===== hdl/speckle_contrast_window.sv =====
// ----------------------------------------------------------------------------
// speckle_contrast_window
// Squared spatial speckle contrast over a centred square window.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel in raster order (tuser = 1 marks a padding
// item, which stores zero on an image position). After a frame, send
// HALF*image_width + HALF padding items to drain it, HALF = WINDOW_SIZE/2.
// Each item from position HALF*image_width + HALF on yields one result on the
// m_ channel: tdata = K^2 in unsigned Q5.16, tuser = dark (window sum zero),
// tlast = result for the frame's last pixel.
// An item with no result leaves the block idle and ready for the next. For an
// item with a result, the window is fetched one element per cycle over the
// line store's read port into a chain of window cells, and the ratio comes
// from a bit-serial divider; a dark window skips the divide. The output
// register holds a result while the next item is taken.
// Reset (synchronous, aresetn low) clears counters and the window and sets
// the image size to 640x480; a register write restarts the frame. A stalled
// m_tready holds the result, and the block waits before presenting the next.
// Configuration writes are for idle time only.
// ----------------------------------------------------------------------------
module speckle_contrast_window
    import scw_pkg::*;
#(
    parameter int WINDOW_SIZE = 5,
    parameter int MAX_WIDTH   = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // tdata: pixel[7:0]
    input  logic [PIX_W-1:0]       s_tdata,
    // tuser: req_type
    input  logic                   s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata: contrast_sq[20:0], zeros above
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // tuser: dark
    output logic                   m_tuser,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [REG_W-1:0]       cfg_wdata
);

    localparam int N    = WINDOW_SIZE * WINDOW_SIZE;
    localparam int HALF = WINDOW_SIZE / 2;
    localparam int SR   = WINDOW_SIZE + 2;
    localparam int SLW  = $clog2(SR);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WRW  = $clog2(MAX_WIDTH + 1);
    localparam int DW   = $clog2(WINDOW_SIZE);
    localparam int SW   = $clog2(N * 255 + 1);
    localparam int QSW  = $clog2(N * 65025 + 1);
    localparam int SSW  = 2 * SW;
    localparam int NQW  = $clog2(N * N * 65025 + 1);
    localparam int LN   = $clog2(N);
    localparam int QTW  = FRAC_BITS + LN;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SUB   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] x);
        slot_inc = (x == SLW'(SR - 1)) ? '0 : x + 1'b1;
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [WRW-1:0]      width_reg;
    logic [ROW_W-1:0]    height_reg;
    logic [CW-1:0]       cin_reg;
    logic [ROW_W-1:0]    rin_reg;
    logic [SLW-1:0]      wslot_reg;
    logic [CW-1:0]       ocol_reg;
    logic [ROW_W-1:0]    orow_reg;
    logic [SLW-1:0]      oslot_reg;
    logic                last_reg;
    logic signed [ROW_W:0] r_reg;
    logic signed [CW+1:0]  c_reg;
    logic [SLW-1:0]      rslot_reg;
    logic [DW-1:0]       dx_reg, dy_reg;
    logic                iss_reg, ok_reg;
    logic [PIX_W-1:0]    rd_q_reg;
    logic [SW-1:0]       s_reg;
    logic [QSW-1:0]      q_reg;
    logic [SSW-1:0]      ss_reg;
    logic [NQW-1:0]      nq_reg;
    logic                dark_reg;
    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_contrast_reg;
    logic                m_dark_reg, m_last_reg;

    logic [PIX_W-1:0]    line_mem [SR << CW];

    logic                in_acc, has_result, is_last, frame_end;
    logic                wr_en, rd_ok, out_load, div_start, div_done;
    logic [SLW+CW-1:0]   waddr, raddr;
    logic [PIX_W-1:0]    wdata;
    logic [SLW:0]        start_slot;
    logic [QTW-1:0]      quot;
    logic [31:0]         quot_ext;
    logic [OUT_W-1:0]    contrast;
    logic [WRW-1:0]      wclamp;
    logic [ROW_W-1:0]    hclamp;
    px_t                 link [N+1];
    px_t                 enter_px;
    logic [PIX_W-1:0]    enter_pix;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // Position of the item and of the output it completes
    assign has_result = (rin_reg > ROW_W'(HALF)) ||
                        ((rin_reg == ROW_W'(HALF)) && (cin_reg >= CW'(HALF)));
    assign is_last    = (orow_reg == height_reg - 1'b1) &&
                        (WRW'(ocol_reg) == width_reg - 1'b1);
    assign frame_end  = has_result && is_last;

    // Clamp register writes to their legal ranges
    always_comb begin
        if (32'(cfg_wdata) < 32'(SIZE_FLOOR)) begin
            wclamp = WRW'(SIZE_FLOOR);
        end else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) begin
            wclamp = WRW'(MAX_WIDTH);
        end else begin
            wclamp = WRW'(cfg_wdata);
        end
        if (32'(cfg_wdata) < 32'(SIZE_FLOOR)) begin
            hclamp = ROW_W'(SIZE_FLOOR);
        end else if (32'(cfg_wdata) > 32'(HEIGHT_LIMIT)) begin
            hclamp = ROW_W'(HEIGHT_LIMIT);
        end else begin
            hclamp = ROW_W'(cfg_wdata);
        end
    end

    // Line store: write on accept within the image height, one read per fetch cycle
    assign wr_en = in_acc && (rin_reg < height_reg);
    assign waddr = {wslot_reg, cin_reg};
    assign wdata = (s_tuser == REQ_PAD) ? '0 : s_tdata;
    assign raddr = {rslot_reg, c_reg[CW-1:0]};
    assign rd_ok = (r_reg >= 0) && (r_reg < $signed({1'b0, height_reg})) &&
                   (c_reg >= 0) &&
                   (c_reg < $signed({{(CW+2-WRW){1'b0}}, width_reg}));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[waddr] <= wdata;
        end
        rd_q_reg <= line_mem[raddr];
    end

    assign start_slot = ((SLW+1)'(oslot_reg) + (SLW+1)'(SR - HALF) >= (SLW+1)'(SR)) ?
                        (SLW+1)'(oslot_reg) + (SLW+1)'(SR - HALF) - (SLW+1)'(SR) :
                        (SLW+1)'(oslot_reg) + (SLW+1)'(SR - HALF);

    // Window cell chain; running sums add the entering and drop the leaving
    assign enter_pix = ok_reg ? rd_q_reg : '0;
    assign enter_px  = '{sq: SQ_W'(enter_pix) * SQ_W'(enter_pix), pix: enter_pix};
    assign link[0]   = enter_px;

    for (genvar i = 0; i < N; i++) begin : g_cell
        scw_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (iss_reg),
            .d        (link[i]),
            .q        (link[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_reg <= '0;
            q_reg <= '0;
        end else if (iss_reg) begin
            s_reg <= SW'((SW+1)'(s_reg) + (SW+1)'(enter_px.pix) - (SW+1)'(link[N].pix));
            q_reg <= QSW'((QSW+1)'(q_reg) + (QSW+1)'(enter_px.sq) - (QSW+1)'(link[N].sq));
        end
    end

    // Ratio: squares, numerator, then the serial divide
    assign div_start = (state_reg == ST_SUB) && (s_reg != '0);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            ss_reg <= SSW'(s_reg) * SSW'(s_reg);
            nq_reg <= NQW'(q_reg) * NQW'(N);
        end
        if (state_reg == ST_SUB) begin
            dark_reg <= (s_reg == '0);
        end
    end

    scw_divider #(
        .NUM_W (NQW),
        .DEN_W (SSW),
        .LN    (LN),
        .FRAC  (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (nq_reg - NQW'(ss_reg)),
        .den     (ss_reg),
        .done    (div_done),
        .quot    (quot)
    );

    assign quot_ext = 32'(quot);
    assign contrast = dark_reg ? '0 :
                      (quot_ext > 32'(OUT_MAX)) ? OUT_MAX : quot_ext[OUT_W-1:0];
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_acc && has_result) state_next = ST_FETCH;
            ST_FETCH: begin
                if (dx_reg == DW'(WINDOW_SIZE - 1) && dy_reg == DW'(WINDOW_SIZE - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUB;
            ST_SUB:   state_next = (s_reg == '0) ? ST_OUT : ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= WRW'(640);
            height_reg  <= ROW_W'(480);
            cin_reg     <= '0;
            rin_reg     <= '0;
            wslot_reg   <= '0;
            ocol_reg    <= '0;
            orow_reg    <= '0;
            oslot_reg   <= '0;
            last_reg    <= 1'b0;
            iss_reg     <= 1'b0;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            iss_reg   <= (state_reg == ST_FETCH);
            ok_reg    <= (state_reg == ST_FETCH) && rd_ok;

            // Register writes restart the frame
            if (cfg_wr_en && (cfg_index == REG_IMAGE_WIDTH ||
                              cfg_index == REG_IMAGE_HEIGHT)) begin
                if (cfg_index == REG_IMAGE_WIDTH) begin
                    width_reg <= wclamp;
                end else begin
                    height_reg <= hclamp;
                end
                cin_reg   <= '0;
                rin_reg   <= '0;
                wslot_reg <= '0;
                ocol_reg  <= '0;
                orow_reg  <= '0;
                oslot_reg <= '0;
            end

            // Advance the input position
            if (in_acc) begin
                last_reg <= frame_end;
                if (frame_end) begin
                    cin_reg   <= '0;
                    rin_reg   <= '0;
                    wslot_reg <= '0;
                end else if (WRW'(cin_reg) + 1'b1 >= width_reg) begin
                    cin_reg   <= '0;
                    rin_reg   <= rin_reg + 1'b1;
                    wslot_reg <= slot_inc(wslot_reg);
                end else begin
                    cin_reg <= cin_reg + 1'b1;
                end
            end

            // Present the result and advance the output position
            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (last_reg) begin
                    ocol_reg  <= '0;
                    orow_reg  <= '0;
                    oslot_reg <= '0;
                end else if (WRW'(ocol_reg) == width_reg - 1'b1) begin
                    ocol_reg  <= '0;
                    orow_reg  <= orow_reg + 1'b1;
                    oslot_reg <= slot_inc(oslot_reg);
                end else begin
                    ocol_reg <= ocol_reg + 1'b1;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Fetch address walk over the window, top row first
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            r_reg     <= $signed({1'b0, orow_reg}) - (ROW_W+1)'(HALF);
            c_reg     <= $signed({2'b00, ocol_reg}) - (CW+2)'(HALF);
            rslot_reg <= SLW'(start_slot);
            dx_reg    <= '0;
            dy_reg    <= '0;
        end else if (state_reg == ST_FETCH) begin
            if (dx_reg == DW'(WINDOW_SIZE - 1)) begin
                dx_reg    <= '0;
                dy_reg    <= dy_reg + 1'b1;
                c_reg     <= $signed({2'b00, ocol_reg}) - (CW+2)'(HALF);
                r_reg     <= r_reg + 2'sd1;
                rslot_reg <= slot_inc(rslot_reg);
            end else begin
                dx_reg <= dx_reg + 1'b1;
                c_reg  <= c_reg + 2'sd1;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_contrast_reg <= contrast;
            m_dark_reg     <= dark_reg;
            m_last_reg     <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, m_contrast_reg};
    assign m_tuser  = m_dark_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hdl/scw_cell.sv =====
// ----------------------------------------------------------------------------
// scw_cell
// One window element; passes its value to the next element on each shift.
// ----------------------------------------------------------------------------
module scw_cell
    import scw_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic shift_en,
    input  px_t  d,
    output px_t  q
);

    px_t val_reg;

    // Hold the element, take the neighbor's value on shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (shift_en) begin
            val_reg <= d;
        end
    end

    assign q = val_reg;

endmodule

// ===== hdl/scw_divider.sv =====
// ----------------------------------------------------------------------------
// scw_divider
// Restoring divider, one quotient bit per cycle, for (num << FRAC) / den.
// ----------------------------------------------------------------------------
module scw_divider #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 26,
    parameter int LN    = 5,
    parameter int FRAC  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output logic                  done,
    output logic [FRAC+LN-1:0]    quot
);

    localparam int QW  = FRAC + LN;
    localparam int CNW = $clog2(QW + 1);

    logic [DEN_W:0]   rem_reg;
    logic [QW-1:0]    dlo_reg;
    logic [QW-1:0]    quot_reg;
    logic [CNW-1:0]   cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    // Shift in the next dividend bit and try the subtract
    assign rem_sh = {rem_reg[DEN_W-1:0], dlo_reg[QW-1]};
    assign fits   = rem_sh >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: upper dividend bits seed the remainder, they are below den
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= (DEN_W+1)'(num >> LN);
            dlo_reg  <= {num[LN-1:0], {FRAC{1'b0}}};
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
            dlo_reg  <= {dlo_reg[QW-2:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hdl/scw_checker.sv =====
// ----------------------------------------------------------------------------
// scw_checker
// Port-level checks on the result channel of the speckle contrast window.
// ----------------------------------------------------------------------------
module scw_checker
    import scw_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser,
    input logic                   m_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready
);

    // Hold a stalled item
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Dark windows report zero contrast
    a_dark_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[OUT_W-1:0] == '0)
        else $error("dark result with nonzero contrast");

    // Pad bits above the contrast stay clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_W] == '0)
        else $error("tdata pad bits set");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind speckle_contrast_window scw_checker u_scw_checker (.*);
